@@ hw/rtl/kfce_pkg.sv @@
// ----------------------------------------------------------------------------
// kfce_pkg: shared types and constants for the keyframe curve evaluator
// Item and result words, mode and register codes, controller commands and
// datapath status.
// ----------------------------------------------------------------------------
package kfce_pkg;

  localparam int MAX_KEYS_DEF  = 64;
  localparam int WORDS_PER_KEY = 9;

  // unity in Q16.16 fraction terms
  localparam logic [16:0] Q_ONE = 17'h10000;

  // item modes
  localparam logic [1:0] MODE_WR_TIME   = 2'd0;
  localparam logic [1:0] MODE_WR_WORD   = 2'd1;
  localparam logic [1:0] MODE_EVAL      = 2'd2;
  localparam logic [1:0] MODE_EVAL_WRAP = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CURVE_KIND = 2'd0;
  localparam logic [1:0] CFG_KEY_COUNT  = 2'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         key_slot;
    logic [3:0]         word_slot;
    logic signed [31:0] load_data;
    logic signed [31:0] query_time;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [6:0]         segment_end;
  } result_t;

  // key time read address select
  typedef enum logic [1:0] {
    TS_LAST = 2'd0,
    TS_IDX  = 2'd1,
    TS_PREV = 2'd2
  } tsel_t;

  // weight set-up for end keys and linear segments
  typedef enum logic [1:0] {
    WG_NONE = 2'd0,
    WG_END  = 2'd1,
    WG_LIN  = 2'd2
  } wgt_t;

  // shared multiplier operand select
  typedef enum logic [2:0] {
    MOP_TERM = 3'd0,
    MOP_WW   = 3'd1,
    MOP_FF   = 3'd2,
    MOP_B0   = 3'd3,
    MOP_B1   = 3'd4,
    MOP_B2   = 3'd5,
    MOP_B3   = 3'd6
  } mop_t;

  // destination of a Bezier weight product
  typedef enum logic [2:0] {
    BST_NONE = 3'd0,
    BST_WW   = 3'd1,
    BST_FF   = 3'd2,
    BST_B0   = 3'd3,
    BST_B1   = 3'd4,
    BST_B2   = 3'd5,
    BST_B3   = 3'd6
  } bst_t;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       take_last;
    logic       mod_start;
    logic       take_mod;
    logic       clamp;
    logic       start_idx;
    logic       step_idx;
    logic       seg;
    logic       take_t0;
    logic       take_dd;
    logic       take_abs;
    logic       frac_zero;
    logic       frac_sat;
    logic       frac_start;
    logic       frac_take;
    wgt_t       wgt;
    mop_t       mop;
    bst_t       bst;
    tsel_t      tsel;
    logic [1:0] term;
    logic [1:0] comp;
    logic       term_acc;
    logic       comp_done;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic n_zero;
    logic wrap_go;
    logic div_busy;
    logic i_lt_n;
    logic t_le_time;
    logic at_end;
    logic f_zero;
    logic f_sat;
    logic bez;
    logic vec;
  } status_t;

endpackage

@@ hw/rtl/keyframe_curve_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator_unit: keyframe curve evaluator, Q16.16
// A load word (key time or key word) is taken while idle and gives no
// result. An evaluate word keeps the unit busy through accept, last key
// time, clamp, search start, final search read, segment set-up and output.
// Each key time the segment search steps over is read and compared in turn
// (one read port on the key time store), and one more compare follows when
// the search stops before the last key. Wrapping adds a bit-serial
// remainder. At an end key, each component then reads a single term. Inside
// a segment the fraction needs the 17-step divider unless it is zero or
// saturated. Each term is read, multiplied and summed, and Bezier curves
// first form their weight products. The key word store has one read port, so
// each term of each component is read on its own. The result waits in an
// output register, and the next word is taken while it waits. The output
// step is held off while an earlier result is still waiting.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator_unit import kfce_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  kfce_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_ready    (cfg_ready),
    .status       (status),
    .cmd          (cmd)
  );

  kfce_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

@@ hw/rtl/kfce_div.sv @@
// ----------------------------------------------------------------------------
// kfce_div: restoring divider, one quotient bit per cycle
// Shared by the wrap remainder and the segment fraction.
// ----------------------------------------------------------------------------
module kfce_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dvs,
  input  logic [32:0] rem_init,
  input  logic [31:0] sh_init,
  input  logic [5:0]  steps,
  output logic        busy,
  output logic [32:0] rem,
  output logic [16:0] quo
);

  logic [5:0]  cnt;
  logic [31:0] sh;
  logic [32:0] dv;
  logic [33:0] trial;
  logic [33:0] trial_sub;
  logic        ge;

  // one trial subtraction a cycle
  always_comb begin
    trial     = {rem, sh[31]};
    trial_sub = trial - {1'b0, dv};
    ge        = (trial >= {1'b0, dv});
  end

  assign busy = (cnt != 6'd0);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  // partial remainder, shifted dividend and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      sh  <= sh_init;
      dv  <= dvs;
      quo <= 17'd0;
    end else if (busy) begin
      rem <= ge ? trial_sub[32:0] : trial[32:0];
      sh  <= {sh[30:0], 1'b0};
      quo <= {quo[15:0], ge};
    end
  end

endmodule

@@ hw/rtl/kfce_datapath.sv @@
// ----------------------------------------------------------------------------
// kfce_datapath: key stores, search registers, divider, multiplier, result
// Acts on controller commands; reports status back.
// ----------------------------------------------------------------------------
module kfce_datapath import kfce_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  cmd_t       cmd,
  output status_t    status,
  output result_t    result
);

  localparam int AW    = $clog2(MAX_KEYS);
  localparam int DEPTH = MAX_KEYS * WORDS_PER_KEY;
  localparam int WA    = $clog2(DEPTH);

  // stores
  logic signed [31:0] key_times [MAX_KEYS];
  logic signed [31:0] key_words [DEPTH];
  logic signed [31:0] t_rd;
  logic signed [31:0] w_rd;

  // configuration and cache
  logic [1:0]         curve_kind;
  logic [6:0]         key_count;
  logic [6:0]         n;
  logic signed [31:0] cached_time;
  logic [6:0]         cached_key;

  // evaluation registers
  logic signed [31:0] qtime;
  logic signed [31:0] last_t;
  logic               wrap_r;
  logic [6:0]         idx;
  logic signed [31:0] t0;
  logic signed [33:0] diff;
  logic signed [32:0] den;
  logic [33:0]        adiff;
  logic [32:0]        aden;
  logic               sgn_ne;
  logic               dz;
  logic [16:0]        frac;
  logic [33:0]        ww;
  logic [33:0]        ff;
  logic [16:0]        wgt [4];
  logic signed [54:0] prod;
  logic signed [51:0] acc;
  logic signed [31:0] res [3];

  // combinational helpers
  logic               bez;
  logic               vec;
  logic [3:0]         vs;
  logic [6:0]         tk;
  logic [AW-1:0]      t_addr;
  logic [6:0]         kw;
  logic [3:0]         wo;
  logic [WA-1:0]      ka;
  logic [WA-1:0]      w_addr;
  logic [WA-1:0]      wr_ka;
  logic [WA-1:0]      wr_addr;
  logic               slot_ok;
  logic [16:0]        w_one;
  logic [18:0]        f3;
  logic [18:0]        w3;
  logic signed [34:0] ma;
  logic signed [19:0] mb;
  logic signed [54:0] prod_rnd;
  logic signed [32:0] t_rd_x;
  logic [32:0]        t_rd_abs;
  logic [31:0]        q_abs;
  logic [6:0]         start_k;
  logic signed [51:0] acc_rnd;
  logic signed [35:0] acc_sh;
  logic signed [31:0] acc_sat;
  logic               div_start;
  logic [32:0]        div_dvs;
  logic [32:0]        div_rem_init;
  logic [31:0]        div_sh_init;
  logic [5:0]         div_steps;
  logic               div_busy;
  logic [32:0]        div_rem;
  logic [16:0]        div_quo;

  assign bez = curve_kind[0];
  assign vec = curve_kind[1];
  assign vs  = vec ? 4'd3 : 4'd1;

  // keys in use, limited to the store depth
  always_comb begin
    if (int'(key_count) > MAX_KEYS) begin
      n = 7'(MAX_KEYS);
    end else begin
      n = key_count;
    end
  end

  // key time read address
  always_comb begin
    case (cmd.tsel)
      TS_LAST: tk = n - 7'd1;
      TS_PREV: tk = idx - 7'd1;
      default: tk = idx;
    endcase
    t_addr = AW'(tk);
  end

  // key word read address: key * 9 + word
  always_comb begin
    kw = idx;
    wo = 4'(cmd.comp);
    if (status.at_end) begin
      kw = (idx == 7'd0) ? 7'd0 : n - 7'd1;
      wo = (bez ? vs : 4'd0) + 4'(cmd.comp);
    end else if (!bez) begin
      kw = cmd.term[0] ? idx : idx - 7'd1;
    end else begin
      case (cmd.term)
        2'd0: begin
          kw = idx - 7'd1;
          wo = vs + 4'(cmd.comp);
        end
        2'd1: begin
          kw = idx - 7'd1;
          wo = (vs << 1) + 4'(cmd.comp);
        end
        2'd2: begin
          kw = idx;
        end
        default: begin
          kw = idx;
          wo = vs + 4'(cmd.comp);
        end
      endcase
    end
    ka     = WA'(kw);
    w_addr = (ka << 3) + ka + WA'(wo);
  end

  // load address
  always_comb begin
    slot_ok = (int'(item.key_slot) < MAX_KEYS);
    wr_ka   = WA'(item.key_slot);
    wr_addr = (wr_ka << 3) + wr_ka + WA'(item.word_slot);
  end

  // key time store
  always_ff @(posedge clk) begin
    if (cmd.load && item.mode == MODE_WR_TIME && slot_ok) begin
      key_times[AW'(item.key_slot)] <= item.load_data;
    end
    t_rd <= key_times[t_addr];
  end

  // key word store
  always_ff @(posedge clk) begin
    if (cmd.load && item.mode == MODE_WR_WORD && slot_ok &&
        int'(item.word_slot) < WORDS_PER_KEY) begin
      key_words[wr_addr] <= item.load_data;
    end
    w_rd <= key_words[w_addr];
  end

  // configuration registers and search cache
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind  <= 2'd0;
      key_count   <= 7'd0;
      cached_time <= 32'sd0;
      cached_key  <= 7'd0;
    end else begin
      if (cfg_we && cfg_index == CFG_CURVE_KIND) begin
        curve_kind  <= cfg_data[1:0];
        cached_time <= 32'sd0;
        cached_key  <= 7'd0;
      end else if (cfg_we && cfg_index == CFG_KEY_COUNT) begin
        key_count   <= cfg_data;
        cached_time <= 32'sd0;
        cached_key  <= 7'd0;
      end else if (cmd.load) begin
        cached_time <= 32'sd0;
        cached_key  <= 7'd0;
      end else if (cmd.seg) begin
        cached_time <= qtime;
        cached_key  <= idx;
      end
    end
  end

  // divider operands for the wrap remainder and the fraction
  always_comb begin
    t_rd_x   = 33'(t_rd);
    t_rd_abs = t_rd_x[32] ? 33'(-t_rd_x) : 33'(t_rd_x);
    q_abs    = qtime[31] ? 32'(-qtime) : 32'(qtime);
    div_start = cmd.mod_start | cmd.frac_start;
    if (cmd.frac_start) begin
      div_dvs      = aden;
      div_rem_init = adiff[33:1];
      div_sh_init  = {adiff[0], 31'd0};
      div_steps    = 6'd17;
    end else begin
      div_dvs      = t_rd_abs;
      div_rem_init = 33'd0;
      div_sh_init  = q_abs;
      div_steps    = 6'd32;
    end
  end

  kfce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dvs      (div_dvs),
    .rem_init (div_rem_init),
    .sh_init  (div_sh_init),
    .steps    (div_steps),
    .busy     (div_busy),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  // search start: cached key when time moved forward
  always_comb begin
    start_k = (cached_time < qtime) ? cached_key : 7'd0;
  end

  // query time, wrap, clamp, segment search and segment times
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qtime  <= item.query_time;
      wrap_r <= (item.mode == MODE_EVAL_WRAP);
    end else if (cmd.take_mod) begin
      qtime <= qtime[31] ? -$signed(div_rem[31:0]) : $signed(div_rem[31:0]);
    end else if (cmd.clamp) begin
      if (qtime < 32'sd0) begin
        qtime <= 32'sd0;
      end else if (qtime > last_t) begin
        qtime <= last_t;
      end
    end
    if (cmd.take_last) begin
      last_t <= t_rd;
    end
    if (cmd.start_idx) begin
      idx <= (start_k > n) ? n : start_k;
    end else if (cmd.step_idx) begin
      idx <= idx + 7'd1;
    end
    if (cmd.take_t0) begin
      t0 <= t_rd;
    end
    if (cmd.take_dd) begin
      diff <= 34'(qtime) - 34'(t0);
      den  <= 33'(t_rd) - 33'(t0);
    end
    if (cmd.take_abs) begin
      adiff  <= diff[33] ? 34'(-diff) : 34'(diff);
      aden   <= den[32] ? 33'(-den) : 33'(den);
      sgn_ne <= diff[33] ^ den[32];
      dz     <= (diff == 34'sd0) || (den == 33'sd0);
    end
  end

  // fraction
  always_ff @(posedge clk) begin
    if (cmd.frac_zero) begin
      frac <= 17'd0;
    end else if (cmd.frac_sat) begin
      frac <= Q_ONE;
    end else if (cmd.frac_take) begin
      frac <= (div_quo > Q_ONE) ? Q_ONE : div_quo;
    end
  end

  // shared multiplier operands
  always_comb begin
    w_one = Q_ONE - frac;
    f3    = (19'(frac) << 1) + 19'(frac);
    w3    = (19'(w_one) << 1) + 19'(w_one);
    case (cmd.mop)
      MOP_WW: begin
        ma = $signed(35'(w_one));
        mb = $signed(20'(w_one));
      end
      MOP_FF: begin
        ma = $signed(35'(frac));
        mb = $signed(20'(frac));
      end
      MOP_B0: begin
        ma = $signed(35'(ww));
        mb = $signed(20'(w_one));
      end
      MOP_B1: begin
        ma = $signed(35'(ww));
        mb = $signed(20'(f3));
      end
      MOP_B2: begin
        ma = $signed(35'(ff));
        mb = $signed(20'(w3));
      end
      MOP_B3: begin
        ma = $signed(35'(ff));
        mb = $signed(20'(frac));
      end
      default: begin
        ma = 35'(w_rd);
        mb = $signed(20'(wgt[cmd.term]));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // weights, rounded from 2^48 scale to 2^16 scale
  assign prod_rnd = prod + (55'sd1 <<< 31);

  always_ff @(posedge clk) begin
    case (cmd.bst)
      BST_WW:  ww     <= prod[33:0];
      BST_FF:  ff     <= prod[33:0];
      BST_B0:  wgt[0] <= prod_rnd[48:32];
      BST_B1:  wgt[1] <= prod_rnd[48:32];
      BST_B2:  wgt[2] <= prod_rnd[48:32];
      BST_B3:  wgt[3] <= prod_rnd[48:32];
      default: ;
    endcase
    case (cmd.wgt)
      WG_END: wgt[0] <= Q_ONE;
      WG_LIN: begin
        wgt[0] <= w_one;
        wgt[1] <= frac;
      end
      default: ;
    endcase
  end

  // component accumulate, round and saturate
  always_comb begin
    acc_rnd = acc + 52'sd32768;
    acc_sh  = 36'(acc_rnd >>> 16);
    if (acc_sh > 36'sd2147483647) begin
      acc_sat = 32'sh7fffffff;
    end else if (acc_sh < -36'sd2147483648) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = 32'(acc_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.term_acc) begin
      acc <= ((cmd.term == 2'd0) ? 52'sd0 : acc) + 52'(prod);
    end
    if (cmd.seg) begin
      res[0] <= 32'sd0;
      res[1] <= 32'sd0;
      res[2] <= 32'sd0;
    end else if (cmd.comp_done) begin
      res[cmd.comp] <= acc_sat;
    end
    if (cmd.out_load) begin
      result.out_x       <= res[0];
      result.out_y       <= res[1];
      result.out_z       <= res[2];
      result.segment_end <= idx;
    end
  end

  // status to controller
  always_comb begin
    status           = '0;
    status.is_load   = item.mode inside {MODE_WR_TIME, MODE_WR_WORD};
    status.n_zero    = (n == 7'd0);
    status.wrap_go   = wrap_r && (t_rd != 32'sd0);
    status.div_busy  = div_busy;
    status.i_lt_n    = (idx < n);
    status.t_le_time = (t_rd <= qtime);
    status.at_end    = (idx == 7'd0) || (idx == n);
    status.f_zero    = dz || sgn_ne;
    status.f_sat     = (adiff >= {aden, 1'b0});
    status.bez       = bez;
    status.vec       = vec;
  end

endmodule

@@ hw/rtl/kfce_ctrl.sv @@
// ----------------------------------------------------------------------------
// kfce_ctrl: sequencer for loads and evaluations
// Steps the datapath through wrap, clamp, search, fraction, weights and
// per-component sums, and owns the result valid flag.
// ----------------------------------------------------------------------------
module kfce_ctrl import kfce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  output logic    cfg_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_LAST  = 20'h00002,
    S_MODW  = 20'h00004,
    S_CLAMP = 20'h00008,
    S_START = 20'h00010,
    S_SRD   = 20'h00020,
    S_SCMP  = 20'h00040,
    S_SEG   = 20'h00080,
    S_T0    = 20'h00100,
    S_T1    = 20'h00200,
    S_ABS   = 20'h00400,
    S_FPREP = 20'h00800,
    S_FDIVW = 20'h01000,
    S_WGT   = 20'h02000,
    S_BZ    = 20'h04000,
    S_TRD   = 20'h08000,
    S_TMUL  = 20'h10000,
    S_TACC  = 20'h20000,
    S_COMP  = 20'h40000,
    S_OUT   = 20'h80000
  } state_t;

  state_t     state, state_next;
  logic [1:0] term, term_next;
  logic [1:0] comp, comp_next;
  logic [2:0] bzs, bzs_next;
  logic       out_take;
  logic [1:0] term_last;
  logic [1:0] comp_last;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign out_take   = result_valid && !result_stall;

  always_comb begin
    term_last = status.at_end ? 2'd0 : (status.bez ? 2'd3 : 2'd1);
    comp_last = status.vec ? 2'd2 : 2'd0;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    term_next  = term;
    comp_next  = comp;
    bzs_next   = bzs;
    cmd        = '0;
    cmd.tsel   = TS_IDX;
    cmd.mop    = MOP_TERM;
    cmd.bst    = BST_NONE;
    cmd.wgt    = WG_NONE;
    cmd.term   = term;
    cmd.comp   = comp;
    case (state)
      S_IDLE: begin
        cmd.tsel = TS_LAST;
        if (item_valid) begin
          if (status.is_load) begin
            cmd.load = 1'b1;
          end else if (!status.n_zero) begin
            cmd.capture = 1'b1;
            state_next  = S_LAST;
          end
        end
      end
      S_LAST: begin
        cmd.take_last = 1'b1;
        if (status.wrap_go) begin
          cmd.mod_start = 1'b1;
          state_next    = S_MODW;
        end else begin
          state_next = S_CLAMP;
        end
      end
      S_MODW: begin
        if (!status.div_busy) begin
          cmd.take_mod = 1'b1;
          state_next   = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.start_idx = 1'b1;
        state_next    = S_SRD;
      end
      S_SRD: begin
        state_next = status.i_lt_n ? S_SCMP : S_SEG;
      end
      S_SCMP: begin
        if (status.t_le_time) begin
          cmd.step_idx = 1'b1;
          state_next   = S_SRD;
        end else begin
          state_next = S_SEG;
        end
      end
      S_SEG: begin
        cmd.seg   = 1'b1;
        cmd.tsel  = TS_PREV;
        term_next = 2'd0;
        comp_next = 2'd0;
        if (status.at_end) begin
          cmd.wgt    = WG_END;
          state_next = S_TRD;
        end else begin
          state_next = S_T0;
        end
      end
      S_T0: begin
        cmd.take_t0 = 1'b1;
        state_next  = S_T1;
      end
      S_T1: begin
        cmd.take_dd = 1'b1;
        state_next  = S_ABS;
      end
      S_ABS: begin
        cmd.take_abs = 1'b1;
        state_next   = S_FPREP;
      end
      S_FPREP: begin
        if (status.f_zero) begin
          cmd.frac_zero = 1'b1;
          state_next    = S_WGT;
        end else if (status.f_sat) begin
          cmd.frac_sat = 1'b1;
          state_next   = S_WGT;
        end else begin
          cmd.frac_start = 1'b1;
          state_next     = S_FDIVW;
        end
      end
      S_FDIVW: begin
        if (!status.div_busy) begin
          cmd.frac_take = 1'b1;
          state_next    = S_WGT;
        end
      end
      S_WGT: begin
        if (status.bez) begin
          bzs_next   = 3'd0;
          state_next = S_BZ;
        end else begin
          cmd.wgt    = WG_LIN;
          state_next = S_TRD;
        end
      end
      // weight products, each stored in the cycle after it is formed
      S_BZ: begin
        bzs_next = bzs + 3'd1;
        case (bzs)
          3'd0: cmd.mop = MOP_WW;
          3'd1: begin
            cmd.mop = MOP_FF;
            cmd.bst = BST_WW;
          end
          3'd2: begin
            cmd.mop = MOP_B0;
            cmd.bst = BST_FF;
          end
          3'd3: begin
            cmd.mop = MOP_B1;
            cmd.bst = BST_B0;
          end
          3'd4: begin
            cmd.mop = MOP_B2;
            cmd.bst = BST_B1;
          end
          3'd5: begin
            cmd.mop = MOP_B3;
            cmd.bst = BST_B2;
          end
          default: begin
            cmd.bst    = BST_B3;
            state_next = S_TRD;
          end
        endcase
      end
      S_TRD: begin
        state_next = S_TMUL;
      end
      S_TMUL: begin
        state_next = S_TACC;
      end
      S_TACC: begin
        cmd.term_acc = 1'b1;
        if (term == term_last) begin
          state_next = S_COMP;
        end else begin
          term_next  = term + 2'd1;
          state_next = S_TRD;
        end
      end
      S_COMP: begin
        cmd.comp_done = 1'b1;
        if (comp == comp_last) begin
          state_next = S_OUT;
        end else begin
          comp_next  = comp + 2'd1;
          term_next  = 2'd0;
          state_next = S_TRD;
        end
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      term         <= 2'd0;
      comp         <= 2'd0;
      bzs          <= 3'd0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      term  <= term_next;
      comp  <= comp_next;
      bzs   <= bzs_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (out_take) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
